/* src/xspp_pkg.sv */
// ----------------------------------------------------------------------------
// xspp_pkg
// Shared types, constants and helpers of the X-PAD sub-field planner.
// ----------------------------------------------------------------------------
package xspp_pkg;

	localparam int CI_SLOTS = 4;
	localparam int SLOT_W   = (CI_SLOTS > 1) ? $clog2(CI_SLOTS) : 1;

	localparam logic [7:0] SHORT_CAP   = 8'd4;
	localparam logic [7:0] SHORT_CHUNK = 8'd3;
	localparam logic [7:0] FPAD0_SHORT = 8'h10;
	localparam logic [7:0] FPAD0_VAR   = 8'h20;
	localparam logic [7:0] FPAD1_CI    = 8'h02;
	localparam logic [7:0] FPAD_NONE   = 8'h00;
	localparam logic [7:0] END_MARK    = 8'h00;
	localparam logic [7:0] LEN_BIAS    = 8'd2;

	localparam logic [7:0] SIZE_TABLE [8] = '{
		8'd4, 8'd6, 8'd8, 8'd12, 8'd16, 8'd24, 8'd32, 8'd48
	};

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_FLUSH  = 1'b1
	} xspp_op_t;

	typedef enum logic {
		KIND_APPEND = 1'b0,
		KIND_HEADER = 1'b1
	} xspp_kind_t;

	typedef struct packed {
		logic [7:0] xpad_fill;
		logic [7:0] payload_fill;
		logic [2:0] ci_count;
		logic       cont_valid;
		logic [4:0] cont_type;
		logic [7:0] prev_fill;
	} xspp_state_t;

	typedef struct packed {
		logic       ignore;
		logic [7:0] chunk_len;
		logic [7:0] take_len;
		logic [4:0] apptype_used;
		logic       with_ci;
		logic [2:0] size_code;
		logic       flushable;
		logic [7:0] xpad_fill_nx;
		logic [7:0] payload_fill_nx;
		logic [2:0] ci_count_nx;
		logic       cont_valid_nx;
	} xspp_plan_t;

	function automatic logic [2:0] slot_limit(input logic is_short);
		return is_short ? 3'd1 : 3'(CI_SLOTS);
	endfunction

	function automatic logic [1:0] ci_need(input logic is_short, input logic [2:0] cnt);
		logic [2:0] lim;
		lim = slot_limit(is_short);
		if (!is_short && cnt == 3'd0) begin
			return 2'd2;
		end else if (!is_short && cnt == lim - 3'd1) begin
			return 2'd0;
		end
		return 2'd1;
	endfunction

endpackage

/* src/xspp_ifs.sv */
// ----------------------------------------------------------------------------
// xspp channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface xspp_req_if import xspp_pkg::*; ();
	logic       valid;
	logic       ready;
	xspp_op_t   op;
	logic [15:0] dg_available;
	logic       dg_started;
	logic [4:0] apptype_first;
	logic [4:0] apptype_next;

	modport source (output valid, op, dg_available, dg_started, apptype_first,
		apptype_next, input ready);
	modport sink (input valid, op, dg_available, dg_started, apptype_first,
		apptype_next, output ready);
endinterface

interface xspp_rsp_if import xspp_pkg::*; ();
	logic       valid;
	logic       ready;
	xspp_kind_t kind;
	logic [7:0] chunk_len;
	logic [7:0] take_len;
	logic [4:0] apptype_used;
	logic       with_ci;
	logic       flushable;
	logic [7:0] header_byte;
	logic [7:0] payload_total;
	logic       last;

	modport source (output valid, kind, chunk_len, take_len, apptype_used, with_ci,
		flushable, header_byte, payload_total, last, input ready);
	modport sink (input valid, kind, chunk_len, take_len, apptype_used, with_ci,
		flushable, header_byte, payload_total, last, output ready);
endinterface

interface xspp_cfg_if ();
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/xspp_plan.sv */
// ----------------------------------------------------------------------------
// xspp_plan
// Sub-field decision for an append item against the current frame state.
// ----------------------------------------------------------------------------
module xspp_plan import xspp_pkg::*; (
	input  logic        is_short,
	input  logic [7:0]  capacity,
	input  xspp_state_t st,
	input  logic [15:0] dg_available,
	input  logic        dg_started,
	input  logic [4:0]  apptype_first,
	input  logic [4:0]  apptype_next,
	output xspp_plan_t  plan
);

	logic [2:0]        lim;
	logic [1:0]        need0;
	logic [1:0]        need1;
	logic signed [9:0] room0;
	logic signed [9:0] room1;
	logic              full0;
	logic [7:0]        fit;
	logic [2:0]        k1;
	logic [2:0]        k2;
	logic [2:0]        code;
	logic [8:0]        capw;
	logic [8:0]        prevw;
	logic [8:0]        s9;
	logic              var_ok;
	logic              cont_ok;
	logic              use_ci;
	logic [7:0]        chunk;
	logic [7:0]        take;
	logic [7:0]        fill1;
	logic [2:0]        cnt1;
	logic              full1;

	assign lim   = slot_limit(is_short);
	assign need0 = ci_need(is_short, st.ci_count);
	assign room0 = $signed({2'b00, capacity}) - $signed({2'b00, st.xpad_fill});

	assign full0 = (st.xpad_fill != 8'd0 && st.ci_count == 3'd0) || (st.ci_count >= lim) ||
		(!is_short && $signed(10'(SIZE_TABLE[0]) + 10'(need0)) > room0);

	always_comb begin
		k1 = 3'd0;
		k2 = 3'd0;
		for (int k = 0; k < 8; k++) begin
			fit[k] = $signed(10'(SIZE_TABLE[k]) + 10'(need0)) <= room0;
		end
		for (int k = 0; k < 7; k++) begin
			if (16'(SIZE_TABLE[k]) < dg_available) begin
				k1 = 3'(k + 1);
			end
		end
		for (int k = 0; k < 8; k++) begin
			if (3'(k) <= k1 && fit[k]) begin
				k2 = 3'(k);
			end
		end
		code = k2;
		if (k2 != 3'd0 && ({1'b0, dg_available} + 17'd4) <= 17'(SIZE_TABLE[k2])) begin
			code = k2 - 3'd1;
		end
		if (is_short) begin
			code = 3'd0;
		end
	end

	assign capw  = {1'b0, capacity};
	assign prevw = {1'b0, st.prev_fill};
	assign s9    = 9'(CI_SLOTS);
	assign var_ok = (capw >= s9) && (prevw >= capw - s9) && (prevw >= s9) &&
		(dg_available >= 16'(prevw - s9));

	assign cont_ok = (st.ci_count == 3'd0) && st.cont_valid && (st.cont_type == apptype_next) &&
		(st.prev_fill != 8'd0) && (st.prev_fill <= capacity) && (is_short || var_ok);
	assign use_ci = !cont_ok;

	assign chunk = use_ci ? (is_short ? SHORT_CHUNK : SIZE_TABLE[code]) : st.prev_fill;
	assign take  = (dg_available < {8'd0, chunk}) ? dg_available[7:0] : chunk;
	assign fill1 = st.xpad_fill + chunk + (use_ci ? {6'd0, need0} : 8'd0);
	assign cnt1  = st.ci_count + 3'd1;
	assign need1 = ci_need(is_short, cnt1);
	assign room1 = $signed({2'b00, capacity}) - $signed({2'b00, fill1});
	assign full1 = !use_ci || (cnt1 == lim) ||
		($signed(10'(SIZE_TABLE[0]) + 10'(need1)) > room1);

	always_comb begin
		plan.ignore          = (dg_available == 16'd0) || full0;
		plan.apptype_used    = dg_started ? apptype_next : apptype_first;
		plan.size_code       = code;
		plan.xpad_fill_nx    = fill1;
		plan.payload_fill_nx = st.payload_fill + chunk;
		plan.ci_count_nx     = use_ci ? cnt1 : st.ci_count;
		plan.cont_valid_nx   = dg_available > {8'd0, take};
		if (plan.ignore) begin
			plan.chunk_len = 8'd0;
			plan.take_len  = 8'd0;
			plan.with_ci   = 1'b0;
			plan.flushable = full0;
		end else begin
			plan.chunk_len = chunk;
			plan.take_len  = take;
			plan.with_ci   = use_ci;
			plan.flushable = full1;
		end
	end

endmodule

/* src/xspp_flush.sv */
// ----------------------------------------------------------------------------
// xspp_flush
// Header byte selection for one position of a frame flush.
// ----------------------------------------------------------------------------
module xspp_flush import xspp_pkg::*; (
	input  logic        is_short,
	input  xspp_state_t st,
	input  logic [2:0]  pos,
	input  logic [4:0]  slot_type,
	input  logic [2:0]  slot_code,
	output logic [7:0]  header_byte,
	output logic        last
);

	logic [2:0] lim;
	logic       has_data;
	logic       has_ci;
	logic [3:0] hdr_n;
	logic [3:0] p;
	logic [2:0] code;
	logic [7:0] f0;
	logic [7:0] f1;

	assign lim      = slot_limit(is_short);
	assign has_data = st.payload_fill != 8'd0;
	assign has_ci   = has_data && st.ci_count != 3'd0;
	assign hdr_n    = has_ci ? ({1'b0, st.ci_count} + {3'd0, st.ci_count < lim}) : 4'd0;
	assign p        = {1'b0, pos};
	assign code     = is_short ? 3'd0 : slot_code;
	assign f0       = has_data ? (is_short ? FPAD0_SHORT : FPAD0_VAR) : FPAD_NONE;
	assign f1       = has_ci ? FPAD1_CI : FPAD_NONE;

	always_comb begin
		last = 1'b0;
		if (has_ci && p < {1'b0, st.ci_count}) begin
			header_byte = {code, slot_type};
		end else if (p < hdr_n) begin
			header_byte = END_MARK;
		end else if (p == hdr_n) begin
			header_byte = f0;
		end else if (p == hdr_n + 4'd1) begin
			header_byte = f1;
		end else begin
			header_byte = st.xpad_fill + LEN_BIAS;
			last        = 1'b1;
		end
	end

endmodule

/* src/xpad_subfield_planner_unit.sv */
// ----------------------------------------------------------------------------
// xpad_subfield_planner_unit
// X-PAD sub-field planner: sizes sub-fields and emits frame headers on flush.
// ----------------------------------------------------------------------------
// cfg writes the X-PAD capacity (4 = short X-PAD); always ready, write only
// while no item is in flight. req carries append and flush items, rsp the
// results. An accepted item sits in an input stage and its first result is
// loaded from there into the result register. An append gives one result and
// a new append can be taken every cycle while rsp is not stalled. A flush
// gives 3 to 7 header results, one per cycle from the shared header selector
// unless rsp stalls, and holds the input stage until its last one is loaded.
// A stalled rsp holds its result; the input stage and req.ready then stall
// one item behind it. Reset clears the frame state, the continuation tracking
// and the previous frame length and sets the capacity to 4.
// ----------------------------------------------------------------------------
module xpad_subfield_planner_unit import xspp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	xspp_cfg_if.sink      cfg,
	xspp_req_if.sink      req,
	xspp_rsp_if.source    rsp
);

	logic [7:0]  cap_q;
	logic        is_short;
	xspp_state_t st_q;
	logic [4:0]  ci_type_q [CI_SLOTS];
	logic [2:0]  ci_code_q [CI_SLOTS];
	logic [2:0]  pos_q;

	logic        v_s1;
	xspp_op_t    op_s1;
	logic [15:0] avail_s1;
	logic        started_s1;
	logic [4:0]  first_s1;
	logic [4:0]  next_s1;

	xspp_plan_t  plan;
	logic [7:0]  fl_byte;
	logic        fl_last;
	logic        out_load;
	logic        s1_done;
	logic        app_commit;

	logic        rsp_v_q;
	xspp_kind_t  kind_q;
	logic [7:0]  chunk_q;
	logic [7:0]  take_q;
	logic [4:0]  app_q;
	logic        ci_q;
	logic        flushable_q;
	logic [7:0]  hdr_q;
	logic [7:0]  tot_q;
	logic        last_q;

	assign is_short  = cap_q == SHORT_CAP;
	assign cfg.ready = 1'b1;

	xspp_plan u_plan (
		.is_short      (is_short),
		.capacity      (cap_q),
		.st            (st_q),
		.dg_available  (avail_s1),
		.dg_started    (started_s1),
		.apptype_first (first_s1),
		.apptype_next  (next_s1),
		.plan          (plan)
	);

	xspp_flush u_flush (
		.is_short    (is_short),
		.st          (st_q),
		.pos         (pos_q),
		.slot_type   (ci_type_q[pos_q[SLOT_W-1:0]]),
		.slot_code   (ci_code_q[pos_q[SLOT_W-1:0]]),
		.header_byte (fl_byte),
		.last        (fl_last)
	);

	assign out_load   = v_s1 && (!rsp_v_q || rsp.ready);
	assign s1_done    = out_load && (op_s1 == OP_APPEND || fl_last);
	assign app_commit = s1_done && op_s1 == OP_APPEND && !plan.ignore;
	assign req.ready  = !v_s1 || s1_done;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1      <= req.op;
			avail_s1   <= req.dg_available;
			started_s1 <= req.dg_started;
			first_s1   <= req.apptype_first;
			next_s1    <= req.apptype_next;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= SHORT_CAP;
			st_q  <= '0;
			pos_q <= 3'd0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end
			if (app_commit) begin
				st_q.xpad_fill    <= plan.xpad_fill_nx;
				st_q.payload_fill <= plan.payload_fill_nx;
				st_q.ci_count     <= plan.ci_count_nx;
				st_q.cont_valid   <= plan.cont_valid_nx;
				if (plan.cont_valid_nx) begin
					st_q.cont_type <= next_s1;
				end
			end
			if (s1_done && op_s1 == OP_FLUSH) begin
				st_q.prev_fill    <= st_q.xpad_fill;
				st_q.xpad_fill    <= 8'd0;
				st_q.payload_fill <= 8'd0;
				st_q.ci_count     <= 3'd0;
				if (st_q.payload_fill == 8'd0) begin
					st_q.cont_valid <= 1'b0;
				end
			end
			if (out_load && op_s1 == OP_FLUSH) begin
				pos_q <= fl_last ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	// ci slots
	always_ff @(posedge clk) begin
		if (app_commit && plan.with_ci) begin
			ci_type_q[st_q.ci_count[SLOT_W-1:0]] <= plan.apptype_used;
			ci_code_q[st_q.ci_count[SLOT_W-1:0]] <= plan.size_code;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (out_load) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (op_s1 == OP_APPEND) begin
				kind_q      <= KIND_APPEND;
				chunk_q     <= plan.chunk_len;
				take_q      <= plan.take_len;
				app_q       <= plan.apptype_used;
				ci_q        <= plan.with_ci;
				flushable_q <= plan.flushable;
				hdr_q       <= 8'd0;
				tot_q       <= 8'd0;
				last_q      <= 1'b1;
			end else begin
				kind_q      <= KIND_HEADER;
				chunk_q     <= 8'd0;
				take_q      <= 8'd0;
				app_q       <= 5'd0;
				ci_q        <= 1'b0;
				flushable_q <= 1'b0;
				hdr_q       <= fl_byte;
				tot_q       <= st_q.payload_fill;
				last_q      <= fl_last;
			end
		end
	end

	assign rsp.valid         = rsp_v_q;
	assign rsp.kind          = kind_q;
	assign rsp.chunk_len     = chunk_q;
	assign rsp.take_len      = take_q;
	assign rsp.apptype_used  = app_q;
	assign rsp.with_ci       = ci_q;
	assign rsp.flushable     = flushable_q;
	assign rsp.header_byte   = hdr_q;
	assign rsp.payload_total = tot_q;
	assign rsp.last          = last_q;

	a_append_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && op_s1 == OP_APPEND) |=> (rsp.last && rsp.kind == KIND_APPEND))
		else $error("append result not single");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && op_s1 == OP_FLUSH) |=>
		(st_q.xpad_fill == 8'd0 && st_q.payload_fill == 8'd0 && st_q.ci_count == 3'd0 &&
		pos_q == 3'd0))
		else $error("frame not cleared after flush");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_done) |-> !req.ready)
		else $error("input taken while stage busy");

	a_flush_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 || op_s1 == OP_APPEND) |-> pos_q == 3'd0)
		else $error("flush position left over");

	a_ignore_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && op_s1 == OP_APPEND && plan.ignore) |=> $stable(st_q.xpad_fill))
		else $error("ignored append changed frame");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the X-PAD sub-field planner. Append and flush
// items go in through the request channel, and a planner model inside the
// bench predicts every answer and header byte. The run starts with a
// directed set in short, large, small and odd capacities. Random phases
// follow, made mostly of data groups that are written frame by frame,
// with some noise items mixed in. Sender idling and receiver stalls change
// from one phase to the next.
// ----------------------------------------------------------------------------
module tb_top import xspp_pkg::*; ();

	localparam int STALL_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_ITEMS    = 44;
	localparam int REPORT_LIMIT   = 30;
	localparam int SEND_IDLE_PCT [4] = '{0, 88, 0, 16};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 88, 16};

	typedef struct packed {
		xspp_op_t    op;
		logic [15:0] dg_available;
		logic        dg_started;
		logic [4:0]  app_first;
		logic [4:0]  app_next;
	} planner_req_t;

	typedef struct packed {
		xspp_kind_t kind;
		logic [7:0] chunk_len;
		logic [7:0] take_len;
		logic [4:0] apptype_used;
		logic       with_ci;
		logic       flushable;
		logic [7:0] header_byte;
		logic [7:0] payload_total;
		logic       last;
	} planner_res_t;

	typedef struct packed {
		logic [7:0]                cap;
		logic [7:0]                xfill;
		logic [7:0]                pfill;
		logic [2:0]                ci_cnt;
		logic [CI_SLOTS-1:0][4:0]  slot_type;
		logic [CI_SLOTS-1:0][2:0]  slot_code;
		logic                      cont_valid;
		logic [4:0]                cont_type;
		logic [7:0]                prev_fill;
	} frame_model_t;

	logic clk;
	logic arst_n;

	xspp_req_if req_ch ();
	xspp_rsp_if rsp_ch ();
	xspp_cfg_if cfg_ch ();

	xpad_subfield_planner_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	frame_model_t frame_state;
	frame_model_t gen_state;
	planner_req_t queued_requests [$];
	planner_res_t planned_results [$];
	planner_req_t req_on_bus;
	int requests_in_flight;
	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int results_checked;
	int ci_subfields;
	int cont_subfields;
	int ignored_appends;
	int flushes_seen;
	int phase_count;
	int stuck_cycles;

	int grp_left;
	bit grp_started;
	int grp_first;
	int grp_next;

	always #5 clk = ~clk;

	function automatic bit short_mode(input frame_model_t m);
		return m.cap == SHORT_CAP;
	endfunction

	function automatic int ci_overhead(input frame_model_t m);
		if (!short_mode(m) && m.ci_cnt == 3'd0) begin
			return 2;
		end
		if (!short_mode(m) && int'(m.ci_cnt) == CI_SLOTS - 1) begin
			return 0;
		end
		return 1;
	endfunction

	function automatic int free_bytes(input frame_model_t m);
		return int'(m.cap) - int'(m.xfill);
	endfunction

	function automatic bit frame_closed(input frame_model_t m);
		int lim;
		lim = short_mode(m) ? 1 : CI_SLOTS;
		if (m.xfill != 8'd0 && m.ci_cnt == 3'd0) begin
			return 1'b1;
		end
		if (int'(m.ci_cnt) >= lim) begin
			return 1'b1;
		end
		return !short_mode(m) && int'(SIZE_TABLE[0]) + ci_overhead(m) > free_bytes(m);
	endfunction

	function automatic int best_size_code(input frame_model_t m, input int avail);
		int k;
		int need;
		int room;
		k = 0;
		need = ci_overhead(m);
		room = free_bytes(m);
		while (k + 1 < 8 && int'(SIZE_TABLE[k]) < avail) begin
			k++;
		end
		while (k > 0 && int'(SIZE_TABLE[k]) + need > room) begin
			k--;
		end
		if (k > 0 && int'(SIZE_TABLE[k]) - avail >= int'(SIZE_TABLE[0])) begin
			k--;
		end
		return k;
	endfunction

	function automatic void plan_subfield_step(ref frame_model_t m, input planner_req_t it,
		ref planner_res_t res [$]);
		planner_res_t r;
		int avail;
		int chunk;
		int take;
		int code;
		int slots;
		int cap_i;
		int prev_i;
		bit is_short;
		bit use_ci;
		bit full;
		logic [7:0] f0;
		logic [7:0] f1;
		r = '0;
		is_short = short_mode(m);
		slots = is_short ? 1 : CI_SLOTS;
		cap_i = int'(m.cap);
		prev_i = int'(m.prev_fill);
		avail = int'(it.dg_available);
		if (it.op == OP_APPEND) begin
			r.kind = KIND_APPEND;
			r.last = 1'b1;
			r.apptype_used = it.dg_started ? it.app_next : it.app_first;
			if (avail == 0 || frame_closed(m)) begin
				r.flushable = frame_closed(m);
				res.insert(res.size(), r);
				return;
			end
			use_ci = !(m.ci_cnt == 3'd0 && m.cont_valid && m.cont_type == it.app_next &&
				prev_i > 0 && prev_i <= cap_i &&
				(is_short || (cap_i >= slots && prev_i >= cap_i - slots &&
				prev_i >= slots && avail >= prev_i - slots)));
			if (use_ci) begin
				code = is_short ? 0 : best_size_code(m, avail);
				chunk = is_short ? int'(SHORT_CHUNK) : int'(SIZE_TABLE[code]);
				take = avail < chunk ? avail : chunk;
				m.pfill += 8'(chunk);
				m.xfill += 8'(chunk);
				m.slot_type[m.ci_cnt[1:0]] = r.apptype_used;
				m.slot_code[m.ci_cnt[1:0]] = 3'(code);
				m.xfill += 8'(ci_overhead(m));
				m.ci_cnt += 3'd1;
				full = int'(m.ci_cnt) == slots ||
					int'(SIZE_TABLE[0]) + ci_overhead(m) > free_bytes(m);
			end else begin
				chunk = prev_i;
				take = avail < chunk ? avail : chunk;
				m.pfill += 8'(chunk);
				m.xfill += 8'(chunk);
				full = 1'b1;
			end
			if (avail - take > 0) begin
				m.cont_valid = 1'b1;
				m.cont_type = it.app_next;
			end else begin
				m.cont_valid = 1'b0;
			end
			r.chunk_len = 8'(chunk);
			r.take_len = 8'(take);
			r.with_ci = use_ci;
			r.flushable = full;
			res.insert(res.size(), r);
		end else begin
			r.kind = KIND_HEADER;
			r.payload_total = m.pfill;
			if (m.pfill != 8'd0) begin
				for (int i = 0; i < int'(m.ci_cnt) && i < CI_SLOTS; i++) begin
					r.header_byte = {is_short ? 3'd0 : m.slot_code[i], m.slot_type[i]};
					res.insert(res.size(), r);
				end
				if (m.ci_cnt != 3'd0 && int'(m.ci_cnt) < slots) begin
					r.header_byte = END_MARK;
					res.insert(res.size(), r);
				end
				f0 = is_short ? FPAD0_SHORT : FPAD0_VAR;
				f1 = (m.ci_cnt != 3'd0) ? FPAD1_CI : FPAD_NONE;
			end else begin
				m.cont_valid = 1'b0;
				f0 = FPAD_NONE;
				f1 = FPAD_NONE;
			end
			r.header_byte = f0;
			res.insert(res.size(), r);
			r.header_byte = f1;
			res.insert(res.size(), r);
			r.header_byte = m.xfill + LEN_BIAS;
			r.last = 1'b1;
			res.insert(res.size(), r);
			m.prev_fill = m.xfill;
			m.xfill = 8'd0;
			m.pfill = 8'd0;
			m.ci_cnt = 3'd0;
		end
	endfunction

	function automatic void queue_request(input xspp_op_t op, input int avail, input bit started,
		input int app_first, input int app_next, output bit counted, output int taken);
		planner_req_t it;
		planner_res_t answer [$];
		it.op = op;
		it.dg_available = 16'(avail);
		it.dg_started = started;
		it.app_first = 5'(app_first);
		it.app_next = 5'(app_next);
		plan_subfield_step(gen_state, it, answer);
		counted = (op == OP_FLUSH) || (answer[0].chunk_len != 8'd0);
		taken = (op == OP_APPEND) ? int'(answer[0].take_len) : 0;
		queued_requests.insert(queued_requests.size(), it);
		requests_in_flight++;
	endfunction

	function automatic void queue_simple(input xspp_op_t op, input int avail, input bit started,
		input int app_first, input int app_next);
		bit counted;
		int taken;
		queue_request(op, avail, started, app_first, app_next, counted, taken);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("%0t: mismatch on %s: got %0h, expected %0h (result %0d)", $realtime,
				what, got, want, results_checked);
		end
	endtask

	task automatic check_result();
		planner_res_t want;
		if (planned_results.size() == 0) begin
			report_mismatch("result with nothing expected", 16'(rsp_ch.kind), 16'd0);
			return;
		end
		want = planned_results[0];
		planned_results.delete(0);
		results_checked++;
		if (want.kind == KIND_APPEND) begin
			if (want.chunk_len == 8'd0) begin
				ignored_appends++;
			end else if (want.with_ci) begin
				ci_subfields++;
			end else begin
				cont_subfields++;
			end
		end else if (want.last) begin
			flushes_seen++;
		end
		if (rsp_ch.kind !== want.kind)
			report_mismatch("kind", 16'(rsp_ch.kind), 16'(want.kind));
		if (rsp_ch.chunk_len !== want.chunk_len)
			report_mismatch("chunk_len", 16'(rsp_ch.chunk_len), 16'(want.chunk_len));
		if (rsp_ch.take_len !== want.take_len)
			report_mismatch("take_len", 16'(rsp_ch.take_len), 16'(want.take_len));
		if (rsp_ch.apptype_used !== want.apptype_used)
			report_mismatch("apptype_used", 16'(rsp_ch.apptype_used), 16'(want.apptype_used));
		if (rsp_ch.with_ci !== want.with_ci)
			report_mismatch("with_ci", 16'(rsp_ch.with_ci), 16'(want.with_ci));
		if (rsp_ch.flushable !== want.flushable)
			report_mismatch("flushable", 16'(rsp_ch.flushable), 16'(want.flushable));
		if (rsp_ch.header_byte !== want.header_byte)
			report_mismatch("header_byte", 16'(rsp_ch.header_byte), 16'(want.header_byte));
		if (rsp_ch.payload_total !== want.payload_total)
			report_mismatch("payload_total", 16'(rsp_ch.payload_total), 16'(want.payload_total));
		if (rsp_ch.last !== want.last)
			report_mismatch("last", 16'(rsp_ch.last), 16'(want.last));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				plan_subfield_step(frame_state, req_on_bus, planned_results);
				requests_in_flight--;
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_on_bus = queued_requests[0];
					queued_requests.delete(0);
					req_ch.valid <= 1'b1;
					req_ch.op <= req_on_bus.op;
					req_ch.dg_available <= req_on_bus.dg_available;
					req_ch.dg_started <= req_on_bus.dg_started;
					req_ch.apptype_first <= req_on_bus.app_first;
					req_ch.apptype_next <= req_on_bus.app_next;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_result();
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (requests_in_flight != 0 || planned_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_capacity(input logic [7:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		frame_state.cap = value;
		gen_state.cap = value;
	endtask

	task automatic begin_phase(input logic [7:0] capacity, input bit do_write, input int mode);
		wait_drained();
		if (do_write) begin
			write_capacity(capacity);
		end
		@(negedge clk);
		send_idle_pct = SEND_IDLE_PCT[mode];
		recv_stall_pct = RECV_STALL_PCT[mode];
		phase_count++;
	endtask

	task automatic new_data_group();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60) begin
			grp_left = $urandom_range(60, 1);
		end else if (roll < 90) begin
			grp_left = $urandom_range(400, 61);
		end else begin
			grp_left = $urandom_range(65535, 401);
		end
		grp_started = 1'b0;
		grp_first = $urandom_range(31);
		if ($urandom_range(1) == 0) begin
			grp_next = $urandom_range(31);
		end
	endtask

	task automatic run_random_phase(input logic [7:0] capacity, input int mode);
		int counted_items;
		int roll;
		int taken;
		bit counted;
		begin_phase(capacity, 1'b1, mode);
		counted_items = 0;
		while (counted_items < PHASE_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				queue_request(xspp_op_t'($urandom_range(1)),
					($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(70),
					1'($urandom_range(1)), $urandom_range(31), $urandom_range(31),
					counted, taken);
			end else if (roll < 12 || frame_closed(gen_state)) begin
				queue_request(OP_FLUSH, 0, 1'b0, 0, 0, counted, taken);
			end else begin
				if (grp_left == 0) begin
					new_data_group();
				end
				queue_request(OP_APPEND, grp_left, grp_started, grp_first, grp_next,
					counted, taken);
				grp_left -= taken;
				if (taken > 0) begin
					grp_started = 1'b1;
				end
			end
			if (counted) begin
				counted_items++;
			end
		end
		if ($urandom_range(1) == 0) begin
			queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_APPEND;
		req_ch.dg_available = '0;
		req_ch.dg_started = 1'b0;
		req_ch.apptype_first = '0;
		req_ch.apptype_next = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		frame_state = '0;
		frame_state.cap = SHORT_CAP;
		gen_state = frame_state;
		requests_in_flight = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		results_checked = 0;
		ci_subfields = 0;
		cont_subfields = 0;
		ignored_appends = 0;
		flushes_seen = 0;
		phase_count = 0;
		stuck_cycles = 0;
		grp_left = 0;
		grp_started = 1'b0;
		grp_first = 0;
		grp_next = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// short x-pad at the reset capacity
		begin_phase(SHORT_CAP, 1'b0, 0);
		queue_simple(OP_APPEND, 0, 1'b0, 31, 0);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);
		queue_simple(OP_APPEND, 65535, 1'b0, 31, 31);
		queue_simple(OP_APPEND, 100, 1'b1, 0, 31);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);
		queue_simple(OP_APPEND, 65532, 1'b1, 0, 31);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);
		queue_simple(OP_APPEND, 1, 1'b1, 0, 31);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);

		// largest frame, all four ci slots
		begin_phase(8'd194, 1'b1, 3);
		queue_simple(OP_APPEND, 300, 1'b0, 5, 6);
		queue_simple(OP_APPEND, 3, 1'b0, 7, 8);
		queue_simple(OP_APPEND, 10, 1'b0, 1, 2);
		queue_simple(OP_APPEND, 65535, 1'b0, 31, 31);
		queue_simple(OP_APPEND, 20, 1'b1, 0, 31);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);

		// smallest variable frame, continuation with padding
		begin_phase(8'd6, 1'b1, 1);
		queue_simple(OP_APPEND, 100, 1'b0, 3, 4);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);
		queue_simple(OP_APPEND, 96, 1'b1, 3, 4);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);
		queue_simple(OP_APPEND, 2, 1'b1, 3, 4);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);

		// odd capacity too small for any sub-field
		begin_phase(8'd5, 1'b1, 2);
		queue_simple(OP_APPEND, 10, 1'b0, 9, 9);
		queue_simple(OP_FLUSH, 0, 1'b0, 0, 0);

		run_random_phase(8'd194, 0);
		run_random_phase(SHORT_CAP, 1);
		run_random_phase(8'd52, 2);
		run_random_phase(8'd6, 3);
		run_random_phase(8'($urandom_range(194, 6)), 0);
		run_random_phase(8'd100, 1);
		run_random_phase(8'd7, 2);
		run_random_phase(8'($urandom_range(60, 6)), 3);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (planned_results.size() != 0) begin
			report_mismatch("results never produced", 16'd0, 16'(planned_results.size()));
		end
		$display("%0d results checked over %0d capacity phases, %0d frames flushed",
			results_checked, phase_count, flushes_seen);
		$display("sub-fields: %0d with ci, %0d continuation, %0d appends ignored",
			ci_subfields, cont_subfields, ignored_appends);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* xpad_subfield_planner_unit.f */
src/xspp_pkg.sv
src/xspp_ifs.sv
src/xspp_plan.sv
src/xspp_flush.sv
src/xpad_subfield_planner_unit.sv
tb/sv/tb_top.sv
